### rtl/bmsrch_pkg.sv
`timescale 1ns / 1ps

package bmsrch_pkg;

  // Default geometry of the bitmap.
  localparam int DEF_WORDS     = 32;
  localparam int DEF_WORD_BITS = 32;

  // Fixed field widths of the request and response items.
  localparam int POS_W   = 12;
  localparam int WSEL_W  = 5;
  localparam int OPND_W  = 32;
  localparam int FIDX_W  = 10;
  localparam int WDATA_W = 32;

  typedef enum logic [3:0] {
    OP_TEST        = 4'd0,
    OP_SET         = 4'd1,
    OP_CLEAR       = 4'd2,
    OP_NEXT_SET    = 4'd3,
    OP_PREV_SET    = 4'd4,
    OP_NEXT_CLEAR  = 4'd5,
    OP_PREV_CLEAR  = 4'd6,
    OP_CLEAR_ALL   = 4'd7,
    OP_SET_ALL     = 4'd8,
    OP_AND_WORD    = 4'd9,
    OP_OR_WORD     = 4'd10,
    OP_XOR_WORD    = 4'd11,
    OP_ANDNOT_WORD = 4'd12,
    OP_INVERT_ALL  = 4'd13,
    OP_READ_WORD   = 4'd14
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_DIVQ,
    ST_DIVR,
    ST_BIT,
    ST_SCAN,
    ST_WORD,
    ST_INV,
    ST_FILL,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [3:0]              operation;
    logic signed [POS_W-1:0] position;
    logic [WSEL_W-1:0]       word_select;
    logic [OPND_W-1:0]       operand_word;
  } req_t;

  typedef struct packed {
    logic               found;
    logic [FIDX_W-1:0]  found_index;
    logic               bit_value;
    logic [WDATA_W-1:0] word_data;
  } rsp_t;

endpackage

### rtl/bitmap_set_with_neighbor_search.sv
`timescale 1ns / 1ps

// Bitmap of WORDS words of WORD_BITS bits with single-bit access, whole-map
// operations, word access and nearest set/clear bit search.
// Requests enter on the req channel (req_valid / req_ready) and every request
// returns exactly one response item on the rsp channel (rsp_valid / rsp_ready).
// The block works on one item at a time. Its speed is set by the single read
// port of the bitmap RAM, which delivers one word per cycle: a search reads
// word after word from the start point until a hit or the end of the map,
// and clear all, set all and invert all visit every word of the map in turn.
// The response goes into an output register, so the next request is taken
// while the previous response still waits for the receiver. Only when a
// second response is ready before the first is taken does the block stall.
// After reset (rst, synchronous) the block writes zero to every word of the
// RAM; req_ready stays low during that pass.
module bitmap_set_with_neighbor_search #(
  parameter int WORDS     = bmsrch_pkg::DEF_WORDS,
  parameter int WORD_BITS = bmsrch_pkg::DEF_WORD_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  bmsrch_pkg::req_t   req,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output bmsrch_pkg::rsp_t   rsp
);

  localparam int CAP = WORDS * WORD_BITS;
  localparam int AW  = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int BW  = $clog2(WORD_BITS);
  localparam int IW  = $clog2(CAP + 1);
  // Search start points are non-negative and below 2^(POS_W-1).
  localparam int SW  = bmsrch_pkg::POS_W - 1;
  // Word index by multiplication with a scaled reciprocal of WORD_BITS. The
  // estimate is at most one below the true quotient for any start point.
  localparam int SH    = 16;
  localparam int RECIP = (1 << SH) / WORD_BITS;
  localparam int RW    = $clog2(RECIP + 1);
  localparam int PW    = SW + RW;

  localparam logic [AW-1:0]        LAST_W  = AW'(WORDS - 1);
  localparam logic [BW-1:0]        TOP_BIT = BW'(WORD_BITS - 1);
  localparam logic [WORD_BITS-1:0] ALL1    = '1;

  function automatic logic [BW-1:0] lowest_one(input logic [WORD_BITS-1:0] v);
    logic [BW-1:0] r;
    r = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) r = BW'(i);
    end
    return r;
  endfunction

  function automatic logic [BW-1:0] highest_one(input logic [WORD_BITS-1:0] v);
    logic [BW-1:0] r;
    r = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (v[i]) r = BW'(i);
    end
    return r;
  endfunction

  bmsrch_pkg::state_t state, state_next;
  bmsrch_pkg::req_t   item, item_next;
  bmsrch_pkg::rsp_t   res, res_next;
  bmsrch_pkg::rsp_t   rsp_next;
  logic               rsp_valid_next;
  logic [AW-1:0]      cur_w, cur_w_next;
  logic [IW-1:0]      base, base_next;
  logic [BW-1:0]      bidx, bidx_next;
  logic [SW-1:0]      start, start_next;
  logic [SW-1:0]      q_est, q_est_next;
  logic               first, first_next;
  logic               init_pass, init_pass_next;

  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [WORD_BITS-1:0] wr_data;
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic [WORD_BITS-1:0] rd_data;

  bmsrch_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (WORDS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign req_ready = (state == bmsrch_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bmsrch_pkg::ST_FILL;
      cur_w     <= '0;
      init_pass <= 1'b1;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cur_w     <= cur_w_next;
      init_pass <= init_pass_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    item  <= item_next;
    res   <= res_next;
    rsp   <= rsp_next;
    base  <= base_next;
    bidx  <= bidx_next;
    start <= start_next;
    q_est <= q_est_next;
    first <= first_next;
  end

  always_comb begin
    int                   pos_i;
    int                   start_i;
    int                   rem_i;
    int                   q_i;
    logic [PW-1:0]        prod;
    logic                 want;
    logic                 up;
    logic [WORD_BITS-1:0] cand;
    logic [WORD_BITS-1:0] hit;
    logic [WORD_BITS-1:0] opnd;
    logic [WORD_BITS-1:0] w;
    logic [BW-1:0]        enc;

    state_next     = state;
    item_next      = item;
    res_next       = res;
    rsp_next       = rsp;
    rsp_valid_next = rsp_valid;
    cur_w_next     = cur_w;
    base_next      = base;
    bidx_next      = bidx;
    start_next     = start;
    q_est_next     = q_est;
    first_next     = first;
    init_pass_next = init_pass;
    wr_en          = 1'b0;
    wr_addr        = cur_w;
    wr_data        = '0;
    rd_en          = 1'b0;
    rd_addr        = cur_w;

    pos_i   = int'(item.position);
    start_i = 0;
    rem_i   = 0;
    q_i     = 0;
    prod    = '0;
    want    = (item.operation == bmsrch_pkg::OP_NEXT_SET) ||
              (item.operation == bmsrch_pkg::OP_PREV_SET);
    up      = (item.operation == bmsrch_pkg::OP_NEXT_SET) ||
              (item.operation == bmsrch_pkg::OP_NEXT_CLEAR);
    cand    = want ? rd_data : ~rd_data;
    hit     = '0;
    enc     = '0;
    opnd    = WORD_BITS'(item.operand_word);
    w       = rd_data;

    // The output register empties as soon as the receiver takes the item.
    if (rsp_ready) begin
      rsp_valid_next = 1'b0;
    end

    unique case (state)
      bmsrch_pkg::ST_IDLE: begin
        if (req_valid) begin
          item_next  = req;
          state_next = bmsrch_pkg::ST_DECODE;
        end
      end

      bmsrch_pkg::ST_DECODE: begin
        res_next   = '0;
        cur_w_next = '0;
        state_next = bmsrch_pkg::ST_DONE;
        unique case (item.operation) inside
          bmsrch_pkg::OP_TEST, bmsrch_pkg::OP_SET, bmsrch_pkg::OP_CLEAR: begin
            if (pos_i >= 0 && pos_i < CAP) begin
              start_next = SW'(pos_i);
              state_next = bmsrch_pkg::ST_DIVQ;
            end
          end
          bmsrch_pkg::OP_NEXT_SET, bmsrch_pkg::OP_NEXT_CLEAR: begin
            if (pos_i < CAP - 1) begin
              start_i    = (pos_i < 0) ? 0 : pos_i + 1;
              start_next = SW'(start_i);
              state_next = bmsrch_pkg::ST_DIVQ;
            end
          end
          bmsrch_pkg::OP_PREV_SET, bmsrch_pkg::OP_PREV_CLEAR: begin
            if (item.operation == bmsrch_pkg::OP_PREV_CLEAR && pos_i > CAP) begin
              // Bits beyond the map count as clear, so the bit just below
              // the start point is the answer.
              res_next.found       = 1'b1;
              res_next.found_index = bmsrch_pkg::FIDX_W'(pos_i - 1);
            end else if (pos_i > 0) begin
              start_i    = (pos_i > CAP) ? CAP - 1 : pos_i - 1;
              start_next = SW'(start_i);
              state_next = bmsrch_pkg::ST_DIVQ;
            end
          end
          bmsrch_pkg::OP_CLEAR_ALL, bmsrch_pkg::OP_SET_ALL: begin
            state_next = bmsrch_pkg::ST_FILL;
          end
          bmsrch_pkg::OP_INVERT_ALL: begin
            rd_en      = 1'b1;
            rd_addr    = '0;
            state_next = bmsrch_pkg::ST_INV;
          end
          bmsrch_pkg::OP_AND_WORD, bmsrch_pkg::OP_OR_WORD, bmsrch_pkg::OP_XOR_WORD,
          bmsrch_pkg::OP_ANDNOT_WORD, bmsrch_pkg::OP_READ_WORD: begin
            if (int'(item.word_select) < WORDS) begin
              cur_w_next = AW'(item.word_select);
              rd_en      = 1'b1;
              rd_addr    = AW'(item.word_select);
              state_next = bmsrch_pkg::ST_WORD;
            end
          end
          default: begin
            // Unused code: all-zero response.
          end
        endcase
      end

      bmsrch_pkg::ST_DIVQ: begin
        prod       = PW'(start) * PW'(RECIP);
        q_est_next = SW'(prod >> SH);
        state_next = bmsrch_pkg::ST_DIVR;
      end

      bmsrch_pkg::ST_DIVR: begin
        q_i   = int'(q_est);
        rem_i = int'(start) - q_i * WORD_BITS;
        if (rem_i >= WORD_BITS) begin
          q_i   = q_i + 1;
          rem_i = rem_i - WORD_BITS;
        end
        cur_w_next = AW'(q_i);
        bidx_next  = BW'(rem_i);
        base_next  = IW'(int'(start) - rem_i);
        first_next = 1'b1;
        rd_en      = 1'b1;
        rd_addr    = AW'(q_i);
        if (item.operation == bmsrch_pkg::OP_TEST || item.operation == bmsrch_pkg::OP_SET ||
            item.operation == bmsrch_pkg::OP_CLEAR) begin
          state_next = bmsrch_pkg::ST_BIT;
        end else begin
          state_next = bmsrch_pkg::ST_SCAN;
        end
      end

      bmsrch_pkg::ST_BIT: begin
        res_next.bit_value = (item.operation == bmsrch_pkg::OP_TEST) ? rd_data[bidx] : 1'b0;
        if (item.operation != bmsrch_pkg::OP_TEST) begin
          wr_en   = 1'b1;
          wr_data = rd_data;
          wr_data[bidx] = (item.operation == bmsrch_pkg::OP_SET);
        end
        state_next = bmsrch_pkg::ST_DONE;
      end

      bmsrch_pkg::ST_SCAN: begin
        // Only the first word is trimmed at the start point.
        if (!first) begin
          hit = cand;
        end else if (up) begin
          hit = cand & (ALL1 << bidx);
        end else begin
          hit = cand & (ALL1 >> (TOP_BIT - bidx));
        end
        enc = up ? lowest_one(hit) : highest_one(hit);
        if (|hit) begin
          res_next.found       = 1'b1;
          res_next.found_index = bmsrch_pkg::FIDX_W'(int'(base) + int'(enc));
          state_next           = bmsrch_pkg::ST_DONE;
        end else if (up ? (cur_w == LAST_W) : (cur_w == '0)) begin
          state_next = bmsrch_pkg::ST_DONE;
        end else begin
          first_next = 1'b0;
          rd_en      = 1'b1;
          if (up) begin
            cur_w_next = cur_w + 1'b1;
            rd_addr    = cur_w + 1'b1;
            base_next  = IW'(int'(base) + WORD_BITS);
          end else begin
            cur_w_next = cur_w - 1'b1;
            rd_addr    = cur_w - 1'b1;
            base_next  = IW'(int'(base) - WORD_BITS);
          end
        end
      end

      bmsrch_pkg::ST_WORD: begin
        case (item.operation)
          bmsrch_pkg::OP_AND_WORD:    w = rd_data & opnd;
          bmsrch_pkg::OP_OR_WORD:     w = rd_data | opnd;
          bmsrch_pkg::OP_XOR_WORD:    w = rd_data ^ opnd;
          bmsrch_pkg::OP_ANDNOT_WORD: w = rd_data & ~opnd;
          default:                    w = rd_data;
        endcase
        wr_en              = 1'b1;
        wr_data            = w;
        res_next.word_data = bmsrch_pkg::WDATA_W'(w);
        state_next         = bmsrch_pkg::ST_DONE;
      end

      bmsrch_pkg::ST_INV: begin
        // Write back word cur_w while the next word is being read.
        wr_en   = 1'b1;
        wr_data = ~rd_data;
        if (cur_w == LAST_W) begin
          state_next = bmsrch_pkg::ST_DONE;
        end else begin
          cur_w_next = cur_w + 1'b1;
          rd_en      = 1'b1;
          rd_addr    = cur_w + 1'b1;
        end
      end

      bmsrch_pkg::ST_FILL: begin
        wr_en   = 1'b1;
        wr_data = (!init_pass && item.operation == bmsrch_pkg::OP_SET_ALL) ? ALL1 : '0;
        if (cur_w == LAST_W) begin
          init_pass_next = 1'b0;
          state_next     = init_pass ? bmsrch_pkg::ST_IDLE : bmsrch_pkg::ST_DONE;
        end else begin
          cur_w_next = cur_w + 1'b1;
        end
      end

      bmsrch_pkg::ST_DONE: begin
        if (!rsp_valid || rsp_ready) begin
          rsp_next       = res;
          rsp_valid_next = 1'b1;
          state_next     = bmsrch_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = bmsrch_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

### rtl/bmsrch_ram.sv
`timescale 1ns / 1ps

module bmsrch_ram #(
  parameter int WIDTH = bmsrch_pkg::DEF_WORD_BITS,
  parameter int DEPTH = bmsrch_pkg::DEF_WORDS
) (
  input  logic                                 clk,
  input  logic                                 wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                     wr_data,
  input  logic                                 rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                     rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
